// ===== hdl/fac_pkg.sv =====
// shared constants, types and plane table for the frustum box culler
package fac_pkg;

  localparam int COORD_WIDTH_DEF = 21;
  localparam int BOX_W           = 21;
  localparam int FRAC_BITS       = 10;
  localparam int CAM_W           = 63;
  localparam int SIZE_W          = 42;
  localparam int CFG_DATA_W      = 63;
  localparam int CFG_IDX_W       = 3;
  localparam int N_PLANES        = 6;
  localparam int N_CORNERS       = 8;
  localparam int N_CAM           = 4;
  localparam int N_SIZE          = 3;

  // multiplier slice width and pipeline depth
  localparam int MUL_CHUNK = 24;
  localparam int MUL_LAT   = 3;

  // cycles to hold off the input after a register write while the normals settle
  localparam int SETTLE = 4 + MUL_LAT + 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAM_POSITION    = 3'd0,
    CFG_CAM_FORWARD     = 3'd1,
    CFG_CAM_RIGHT       = 3'd2,
    CFG_CAM_UP          = 3'd3,
    CFG_PLANE_DISTANCES = 3'd4,
    CFG_NEAR_HALF_SIZE  = 3'd5,
    CFG_FAR_HALF_SIZE   = 3'd6
  } cfg_idx_e;

  // corner bit 0: right, bit 1: bottom, bit 2: far
  // per plane: normal = cross(c[a]-c[b], c[d]-c[e]), point c[p]
  localparam logic [2:0] PLANE_TAB [N_PLANES][5] = '{
    '{3'd3, 3'd2, 3'd2, 3'd0, 3'd2},
    '{3'd4, 3'd6, 3'd6, 3'd7, 3'd6},
    '{3'd4, 3'd6, 3'd6, 3'd2, 3'd2},
    '{3'd1, 3'd3, 3'd3, 3'd7, 3'd3},
    '{3'd5, 3'd1, 3'd1, 3'd0, 3'd0},
    '{3'd3, 3'd7, 3'd7, 3'd6, 3'd2}
  };

endpackage

// ===== hdl/fac_mul.sv =====
// pipelined signed multiplier built from narrow slice products
module fac_mul #(
  parameter int AW    = 90,
  parameter int BW    = 45,
  parameter int Chunk = fac_pkg::MUL_CHUNK
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [AW-1:0]  a_i,
  input  logic signed [BW-1:0]  b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NA  = (AW + Chunk - 1) / Chunk;
  localparam int NB  = (BW + Chunk - 1) / Chunk;
  localparam int TA  = AW - (NA - 1) * Chunk;
  localparam int TB  = BW - (NB - 1) * Chunk;
  localparam int PW  = AW + BW;
  localparam int PPW = 2 * (Chunk + 1);

  logic signed [Chunk:0]  pa [NA];
  logic signed [Chunk:0]  pb [NB];
  logic signed [PPW-1:0]  pp_q [NA][NB];
  logic signed [PW-1:0]   row_d [NA];
  logic signed [PW-1:0]   row_q [NA];
  logic signed [PW-1:0]   sum_d;
  logic signed [PW-1:0]   p_q;

  // low slices are unsigned, the top slice carries the sign
  for (genvar i = 0; i < NA; i++) begin : g_pa
    if (i == NA - 1) begin : g_top
      assign pa[i] = (Chunk+1)'(signed'(a_i[AW-1 -: TA]));
    end else begin : g_low
      assign pa[i] = signed'({1'b0, a_i[i*Chunk +: Chunk]});
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_pb
    if (j == NB - 1) begin : g_top
      assign pb[j] = (Chunk+1)'(signed'(b_i[BW-1 -: TB]));
    end else begin : g_low
      assign pb[j] = signed'({1'b0, b_i[j*Chunk +: Chunk]});
    end
  end

  for (genvar i = 0; i < NA; i++) begin : g_row
    for (genvar j = 0; j < NB; j++) begin : g_pp
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pp_q[i][j] <= pa[i] * pb[j];
        end
      end
    end

    always_comb begin
      row_d[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_d[i] = row_d[i] + (PW'(pp_q[i][j]) <<< (j * Chunk));
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        row_q[i] <= row_d[i];
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      sum_d = sum_d + (row_q[i] <<< (i * Chunk));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum_d;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hdl/fac_frustum.sv =====
// camera registers and the free-running pipeline that builds plane normals
module fac_frustum #(
  parameter int CoordWidth = fac_pkg::COORD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fac_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fac_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic signed [4*CoordWidth+5:0]    normal_o [fac_pkg::N_PLANES][3],
  output logic signed [2*CoordWidth+1:0]    point_o  [fac_pkg::N_PLANES][3],
  output logic                              settled_o
);

  localparam int W   = CoordWidth;
  localparam int MW  = 2 * W + 1;
  localparam int CW  = 2 * W + 2;
  localparam int DW  = 2 * W + 3;
  localparam int NW  = 2 * DW;
  localparam int STW = $clog2(fac_pkg::SETTLE + 1);

  logic [fac_pkg::CAM_W-1:0]  cam_q  [fac_pkg::N_CAM];
  logic [fac_pkg::SIZE_W-1:0] size_q [fac_pkg::N_SIZE];
  logic [STW-1:0]             settle_q;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fac_pkg::N_CAM; i++) cam_q[i] <= '0;
      for (int i = 0; i < fac_pkg::N_SIZE; i++) size_q[i] <= '0;
    end else if (cfg_we_i) begin
      case (fac_pkg::cfg_idx_e'(cfg_idx_i))
        fac_pkg::CFG_CAM_POSITION:    cam_q[0]  <= cfg_data_i;
        fac_pkg::CFG_CAM_FORWARD:     cam_q[1]  <= cfg_data_i;
        fac_pkg::CFG_CAM_RIGHT:       cam_q[2]  <= cfg_data_i;
        fac_pkg::CFG_CAM_UP:          cam_q[3]  <= cfg_data_i;
        fac_pkg::CFG_PLANE_DISTANCES: size_q[0] <= cfg_data_i[fac_pkg::SIZE_W-1:0];
        fac_pkg::CFG_NEAR_HALF_SIZE:  size_q[1] <= cfg_data_i[fac_pkg::SIZE_W-1:0];
        fac_pkg::CFG_FAR_HALF_SIZE:   size_q[2] <= cfg_data_i[fac_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= STW'(fac_pkg::SETTLE);
    end else if (cfg_we_i) begin
      settle_q <= STW'(fac_pkg::SETTLE);
    end else if (settle_q != '0) begin
      settle_q <= settle_q - 1'b1;
    end
  end

  assign settled_o = (settle_q == '0);

  // stage 1: scaled camera axes
  logic signed [W-1:0]  pos_q [3];
  logic signed [MW-1:0] fn_q [3], ff_q [3], un_q [3], uf_q [3], rn_q [3], rf_q [3];
  logic signed [W:0]    zn, zf, nw, nh, fw, fh;

  assign zn = signed'({1'b0, size_q[0][0 +: W]});
  assign zf = signed'({1'b0, size_q[0][W +: W]});
  assign nw = signed'({1'b0, size_q[1][0 +: W]});
  assign nh = signed'({1'b0, size_q[1][W +: W]});
  assign fw = signed'({1'b0, size_q[2][0 +: W]});
  assign fh = signed'({1'b0, size_q[2][W +: W]});

  for (genvar k = 0; k < 3; k++) begin : g_axis
    logic signed [W-1:0]  fwd, rt, upv;
    logic signed [MW-1:0] fn_d, ff_d, un_d, uf_d, rn_d, rf_d;

    assign fwd  = signed'(cam_q[1][k*W +: W]);
    assign rt   = signed'(cam_q[2][k*W +: W]);
    assign upv  = signed'(cam_q[3][k*W +: W]);
    assign fn_d = fwd * zn;
    assign ff_d = fwd * zf;
    assign un_d = upv * nh;
    assign uf_d = upv * fh;
    assign rn_d = rt * nw;
    assign rf_d = rt * fw;

    always_ff @(posedge clk_i) begin
      pos_q[k] <= signed'(cam_q[0][k*W +: W]);
      fn_q[k]  <= fn_d;
      ff_q[k]  <= ff_d;
      un_q[k]  <= un_d;
      uf_q[k]  <= uf_d;
      rn_q[k]  <= rn_d;
      rf_q[k]  <= rf_d;
    end
  end

  // stage 2: corners
  logic signed [CW-1:0] corner_q [fac_pkg::N_CORNERS][3];

  for (genvar c = 0; c < fac_pkg::N_CORNERS; c++) begin : g_corner
    for (genvar k = 0; k < 3; k++) begin : g_ck
      logic signed [CW-1:0] cen, vert, horz, pos_s;
      assign pos_s = CW'(pos_q[k]) <<< fac_pkg::FRAC_BITS;
      assign cen   = (c >= 4) ? CW'(ff_q[k]) : CW'(fn_q[k]);
      assign vert  = (c >= 4) ? CW'(uf_q[k]) : CW'(un_q[k]);
      assign horz  = (c >= 4) ? CW'(rf_q[k]) : CW'(rn_q[k]);
      always_ff @(posedge clk_i) begin
        corner_q[c][k] <= pos_s + cen
                        + (((c / 2) % 2 == 1) ? -vert : vert)
                        + ((c % 2 == 1) ? horz : -horz);
      end
    end
  end

  // stage 3: edge vectors; then cross products through the multipliers
  logic signed [DW-1:0] ea_q [fac_pkg::N_PLANES][3];
  logic signed [DW-1:0] eb_q [fac_pkg::N_PLANES][3];
  logic signed [CW-1:0] point_q [fac_pkg::N_PLANES][3];
  logic signed [NW-1:0] normal_q [fac_pkg::N_PLANES][3];

  for (genvar p = 0; p < fac_pkg::N_PLANES; p++) begin : g_plane
    for (genvar k = 0; k < 3; k++) begin : g_pk
      logic signed [NW-1:0] m0, m1;

      always_ff @(posedge clk_i) begin
        ea_q[p][k]    <= DW'(corner_q[fac_pkg::PLANE_TAB[p][0]][k])
                       - DW'(corner_q[fac_pkg::PLANE_TAB[p][1]][k]);
        eb_q[p][k]    <= DW'(corner_q[fac_pkg::PLANE_TAB[p][2]][k])
                       - DW'(corner_q[fac_pkg::PLANE_TAB[p][3]][k]);
        point_q[p][k] <= corner_q[fac_pkg::PLANE_TAB[p][4]][k];
      end

      fac_mul #(.AW(DW), .BW(DW)) u_m0 (
        .clk_i (clk_i),
        .en_i  (1'b1),
        .a_i   (ea_q[p][(k+1)%3]),
        .b_i   (eb_q[p][(k+2)%3]),
        .p_o   (m0)
      );

      fac_mul #(.AW(DW), .BW(DW)) u_m1 (
        .clk_i (clk_i),
        .en_i  (1'b1),
        .a_i   (ea_q[p][(k+2)%3]),
        .b_i   (eb_q[p][(k+1)%3]),
        .p_o   (m1)
      );

      always_ff @(posedge clk_i) begin
        normal_q[p][k] <= m0 - m1;
      end

      assign normal_o[p][k] = normal_q[p][k];
      assign point_o[p][k]  = point_q[p][k];
    end
  end

endmodule

// ===== hdl/fac_test.sv =====
// per-box pipeline: p-vertex select, plane distances, sign test
module fac_test #(
  parameter int CoordWidth = fac_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           out_stall_i,
  input  logic [fac_pkg::BOX_W-1:0]      box_min_i [3],
  input  logic [fac_pkg::BOX_W-1:0]      box_max_i [3],
  input  logic signed [4*CoordWidth+5:0] normal_i [fac_pkg::N_PLANES][3],
  input  logic signed [2*CoordWidth+1:0] point_i  [fac_pkg::N_PLANES][3],
  output logic                           adv_o,
  output logic                           out_valid_o,
  output logic                           visible_o
);

  localparam int W    = CoordWidth;
  localparam int DW   = 2 * W + 3;
  localparam int NW   = 2 * DW;
  localparam int SW   = NW + DW + 2;
  localparam int NSTG = fac_pkg::MUL_LAT + 4;

  logic [NSTG-1:0]      vld_q;
  logic                 adv;
  logic signed [W-1:0]  bmin_q [3], bmax_q [3];
  logic signed [DW-1:0] d_q [fac_pkg::N_PLANES][3];
  logic [fac_pkg::N_PLANES-1:0] neg_q;
  logic                 vis_q;

  // whole pipeline moves unless a finished word is held at the output
  assign adv   = !(vld_q[NSTG-1] && out_stall_i);
  assign adv_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTG-2:0], accept_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        bmin_q[k] <= signed'(box_min_i[k][W-1:0]);
        bmax_q[k] <= signed'(box_max_i[k][W-1:0]);
      end
    end
  end

  for (genvar p = 0; p < fac_pkg::N_PLANES; p++) begin : g_plane
    logic signed [NW+DW-1:0] prod [3];

    for (genvar k = 0; k < 3; k++) begin : g_pk
      logic signed [DW-1:0] v;
      // p-vertex: max where the normal is non-negative
      assign v = normal_i[p][k][NW-1] ? (DW'(bmin_q[k]) <<< fac_pkg::FRAC_BITS)
                                      : (DW'(bmax_q[k]) <<< fac_pkg::FRAC_BITS);
      always_ff @(posedge clk_i) begin
        if (adv) begin
          d_q[p][k] <= v - DW'(point_i[p][k]);
        end
      end

      fac_mul #(.AW(NW), .BW(DW)) u_dot (
        .clk_i (clk_i),
        .en_i  (adv),
        .a_i   (normal_i[p][k]),
        .b_i   (d_q[p][k]),
        .p_o   (prod[k])
      );
    end

    logic signed [SW-1:0] plane_sum;
    assign plane_sum = SW'(prod[0]) + SW'(prod[1]) + SW'(prod[2]);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg_q[p] <= plane_sum[SW-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vis_q <= ~|neg_q;
    end
  end

  assign out_valid_o = vld_q[NSTG-1];
  assign visible_o   = vis_q;

endmodule

// ===== hdl/frustum_aabb_cull.sv =====
// Frustum culling of axis-aligned boxes: takes one box word per cycle while the input is not
// stalled and returns one visible bit per box, in order, through seven register stages
// (box register, p-vertex select, three multiplier stages for the plane distances, sign test,
// output register).
// The six plane normals are derived from the camera registers by a separate pipeline of
// slice multipliers; after any register write, and after reset, the input is stalled while
// that pipeline refills. A stall at the output while a result waits holds the whole pipeline.
module frustum_aabb_cull #(
  parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fac_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fac_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [fac_pkg::BOX_W-1:0] box_min_x_i,
  input  logic signed [fac_pkg::BOX_W-1:0] box_min_y_i,
  input  logic signed [fac_pkg::BOX_W-1:0] box_min_z_i,
  input  logic signed [fac_pkg::BOX_W-1:0] box_max_x_i,
  input  logic signed [fac_pkg::BOX_W-1:0] box_max_y_i,
  input  logic signed [fac_pkg::BOX_W-1:0] box_max_z_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            visible_o
);

  localparam int NW = 4 * COORD_WIDTH + 6;
  localparam int CW = 2 * COORD_WIDTH + 2;

  logic signed [NW-1:0] normal [fac_pkg::N_PLANES][3];
  logic signed [CW-1:0] point  [fac_pkg::N_PLANES][3];
  logic                 settled;
  logic                 adv;
  logic                 accept;
  logic [fac_pkg::BOX_W-1:0] bmin [3];
  logic [fac_pkg::BOX_W-1:0] bmax [3];

  assign in_stall_o = !adv || !settled;
  assign accept     = in_valid_i && !in_stall_o;

  assign bmin[0] = box_min_x_i;
  assign bmin[1] = box_min_y_i;
  assign bmin[2] = box_min_z_i;
  assign bmax[0] = box_max_x_i;
  assign bmax[1] = box_max_y_i;
  assign bmax[2] = box_max_z_i;

  fac_frustum #(.CoordWidth(COORD_WIDTH)) u_frustum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .normal_o   (normal),
    .point_o    (point),
    .settled_o  (settled)
  );

  fac_test #(.CoordWidth(COORD_WIDTH)) u_test (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .out_stall_i (out_stall_i),
    .box_min_i   (bmin),
    .box_max_i   (bmax),
    .normal_i    (normal),
    .point_i     (point),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .visible_o   (visible_o)
  );

endmodule

// ===== tb/sv/frustum_aabb_cull_test.sv =====
// testbench for the frustum box culler: directed and random boxes checked against an exact predictor
module frustum_aabb_cull_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW  = fac_pkg::COORD_WIDTH_DEF;
  localparam int CDW = fac_pkg::CFG_DATA_W;
  typedef logic signed [191:0] wide_t;
  typedef logic signed [fac_pkg::BOX_W-1:0] coord_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [fac_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [CDW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  coord_t box_min_x_i, box_min_y_i, box_min_z_i, box_max_x_i, box_max_y_i, box_max_z_i;
  logic out_valid_o, out_stall_i, visible_o;

  frustum_aabb_cull i_dut (.*);

  logic [CDW-1:0] cam_regs [7];
  logic visible_q [$];
  int errors = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  bit hold_recv = 0;

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("frustum_aabb_cull regression: fail");
    $finish;
  end

  function automatic longint comp_signed(logic [CDW-1:0] r, int k);
    logic [CW-1:0] v;
    v = r[k*CW +: CW];
    return longint'(signed'(v));
  endfunction

  function automatic longint comp_unsigned(logic [CDW-1:0] r, int k);
    return longint'({1'b0, r[k*CW +: CW]});
  endfunction

  // exact p-vertex test over the six planes
  function automatic logic box_visible(coord_t bmn [3], coord_t bmx [3]);
    longint corner [8][3];
    longint zn, zf, nw, nh, fw, fh, pos, fwd, rt, upv, ncen, fcen;
    wide_t a [3], b [3], n [3], dsum, v;
    zn = comp_unsigned(cam_regs[4], 0); zf = comp_unsigned(cam_regs[4], 1);
    nw = comp_unsigned(cam_regs[5], 0); nh = comp_unsigned(cam_regs[5], 1);
    fw = comp_unsigned(cam_regs[6], 0); fh = comp_unsigned(cam_regs[6], 1);
    for (int k = 0; k < 3; k++) begin
      pos = comp_signed(cam_regs[0], k) <<< fac_pkg::FRAC_BITS;
      fwd = comp_signed(cam_regs[1], k);
      rt = comp_signed(cam_regs[2], k);
      upv = comp_signed(cam_regs[3], k);
      ncen = pos + fwd * zn;
      fcen = pos + fwd * zf;
      corner[0][k] = ncen + upv * nh - rt * nw;
      corner[1][k] = ncen + upv * nh + rt * nw;
      corner[2][k] = ncen - upv * nh - rt * nw;
      corner[3][k] = ncen - upv * nh + rt * nw;
      corner[4][k] = fcen + upv * fh - rt * fw;
      corner[5][k] = fcen + upv * fh + rt * fw;
      corner[6][k] = fcen - upv * fh - rt * fw;
      corner[7][k] = fcen - upv * fh + rt * fw;
    end
    for (int p = 0; p < fac_pkg::N_PLANES; p++) begin
      for (int c = 0; c < 3; c++) begin
        a[c] = corner[fac_pkg::PLANE_TAB[p][0]][c] - corner[fac_pkg::PLANE_TAB[p][1]][c];
        b[c] = corner[fac_pkg::PLANE_TAB[p][2]][c] - corner[fac_pkg::PLANE_TAB[p][3]][c];
      end
      n[0] = a[1] * b[2] - a[2] * b[1];
      n[1] = a[2] * b[0] - a[0] * b[2];
      n[2] = a[0] * b[1] - a[1] * b[0];
      dsum = 0;
      for (int c = 0; c < 3; c++) begin
        v = (n[c] < 0) ? wide_t'(bmn[c]) : wide_t'(bmx[c]);
        v = (v <<< fac_pkg::FRAC_BITS) - corner[fac_pkg::PLANE_TAB[p][4]][c];
        dsum += n[c] * v;
      end
      if (dsum < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (visible_q.size() == 0) report_mismatch("result with no box outstanding");
      else begin
        logic e;
        e = visible_q.pop_front();
        if (visible_o !== e) report_mismatch($sformatf("visible %b, want %b", visible_o, e));
      end
    end
  end

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  task automatic write_reg(fac_pkg::cfg_idx_e idx, logic [CDW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 0;
    cam_regs[idx] = val;
  endtask

  task automatic write_raw_idx(logic [fac_pkg::CFG_IDX_W-1:0] idx);
    @(negedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= '1;
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (visible_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  // called at a falling edge; valid stays up between back-to-back words
  task automatic send_box(coord_t mn [3], coord_t mx [3]);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(negedge clk_i);
    end
    in_valid_i <= 1;
    box_min_x_i <= mn[0]; box_min_y_i <= mn[1]; box_min_z_i <= mn[2];
    box_max_x_i <= mx[0]; box_max_y_i <= mx[1]; box_max_z_i <= mx[2];
    do @(posedge clk_i); while (in_stall_o);
    visible_q.push_back(box_visible(mn, mx));
    @(negedge clk_i);
  endtask

  function automatic logic [CDW-1:0] pack3(longint x, longint y, longint z);
    logic [CDW-1:0] r;
    r = '0;
    r[0 +: CW] = CW'(x); r[CW +: CW] = CW'(y); r[2*CW +: CW] = CW'(z);
    return r;
  endfunction

  function automatic coord_t rnd_coord(int span);
    case ($urandom_range(9))
      0: return coord_t'($urandom);
      1: return $urandom_range(1) ? -21'sd1048576 : 21'sd1048575;
      default: return coord_t'(int'($urandom_range(2 * span)) - span);
    endcase
  endfunction

  // sensible camera: axis-aligned basis, mostly, with moderate sizes
  task automatic set_camera(bit wild);
    int ax;
    if (wild) begin
      for (int i = 0; i < 7; i++)
        write_reg(fac_pkg::cfg_idx_e'(i), CDW'({$urandom, $urandom}));
    end else begin
      ax = $urandom_range(2);
      write_reg(fac_pkg::CFG_CAM_POSITION, pack3(int'($urandom_range(8192)) - 4096,
                int'($urandom_range(8192)) - 4096, int'($urandom_range(8192)) - 4096));
      write_reg(fac_pkg::CFG_CAM_FORWARD,
                ax == 0 ? pack3(0, 0, -1024) : pack3(1024, 0, 0));
      write_reg(fac_pkg::CFG_CAM_RIGHT,
                ax == 0 ? pack3(1024, 0, 0) : pack3(0, 0, 1024));
      write_reg(fac_pkg::CFG_CAM_UP, pack3(0, 1024, 0));
      write_reg(fac_pkg::CFG_PLANE_DISTANCES, CDW'({21'($urandom_range(200000, 20000)),
                21'($urandom_range(2000, 100))}));
      write_reg(fac_pkg::CFG_NEAR_HALF_SIZE, CDW'({21'($urandom_range(2000, 100)),
                21'($urandom_range(2000, 100))}));
      write_reg(fac_pkg::CFG_FAR_HALF_SIZE, CDW'({21'($urandom_range(200000, 5000)),
                21'($urandom_range(200000, 5000))}));
    end
  endtask

  task automatic send_random(int count, int span);
    coord_t mn [3], mx [3], t;
    for (int i = 0; i < count; i++) begin
      for (int k = 0; k < 3; k++) begin
        mn[k] = rnd_coord(span);
        mx[k] = rnd_coord(span);
        if ($urandom_range(9) != 0 && mn[k] > mx[k]) begin
          t = mn[k]; mn[k] = mx[k]; mx[k] = t;
        end
      end
      send_box(mn, mx);
    end
  endtask

  task automatic test_reset_frustum();
    coord_t mn [3], mx [3];
    mn = '{-21'sd1048576, 21'sd0, 21'sd1048575};
    mx = '{21'sd1048575, -21'sd1, -21'sd1048576};
    send_box(mn, mx);
    send_box(mx, mn);
    drain();
  endtask

  task automatic test_directed();
    coord_t mn [3], mx [3];
    set_camera(0);
    mn = '{-21'sd10, -21'sd10, -21'sd10}; mx = '{21'sd10, 21'sd10, 21'sd10};
    send_box(mn, mx);
    foreach (mn[k]) begin mn[k] = -21'sd1048576; mx[k] = 21'sd1048575; end
    send_box(mn, mx);
    send_box(mx, mn);  // inverted box
    foreach (mn[k]) begin mn[k] = 21'sd1048575; mx[k] = 21'sd1048575; end
    send_box(mn, mx);
    foreach (mn[k]) begin mn[k] = -21'sd1048576; mx[k] = -21'sd1048576; end
    send_box(mn, mx);
    send_random(15, 250000);
    drain();
    // ignored index, then non-unit vectors at the extremes
    write_raw_idx(3'd7);
    write_reg(fac_pkg::CFG_CAM_FORWARD, '1);
    write_reg(fac_pkg::CFG_CAM_RIGHT, pack3(-1048576, 1048575, 7));
    write_reg(fac_pkg::CFG_PLANE_DISTANCES, CDW'({42{1'b1}}));
    write_reg(fac_pkg::CFG_NEAR_HALF_SIZE, CDW'({42{1'b1}}));
    write_reg(fac_pkg::CFG_FAR_HALF_SIZE, '0);
    send_random(5, 1048575);
    drain();
  endtask

  task automatic test_random(int phases, int per_phase);
    for (int ph = 0; ph < phases; ph++) begin
      set_camera($urandom_range(5) == 0);
      case (ph % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 60; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 60; end
        default: begin send_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      send_random(per_phase, ($urandom_range(1)) ? 300000 : 1048575);
      drain();
    end
    send_idle_pct = 0; recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_recv = 1;
        repeat (80) @(negedge clk_i);
        hold_recv = 0;
      end
      send_random(60, 300000);
    join
    drain();
  endtask

  initial begin
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 0; out_stall_i = 0;
    box_min_x_i = '0; box_min_y_i = '0; box_min_z_i = '0;
    box_max_x_i = '0; box_max_y_i = '0; box_max_z_i = '0;
    foreach (cam_regs[i]) cam_regs[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1;
    test_reset_frustum();
    test_directed();
    test_backpressure();
    test_random(20, 68);
    if (errors == 0) $display("frustum_aabb_cull regression: pass");
    else $display("frustum_aabb_cull regression: fail");
    $finish;
  end
endmodule
